>>> rtl/gfple_pkg.sv
// ----------------------------------------------------------------------------
// gfple_pkg
// Shared constants, types and GF(2^e) arithmetic for the PLE decomposition.
// ----------------------------------------------------------------------------
package gfple_pkg;

  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLUMNS = 16;
  localparam int MAX_DEGREE  = 8;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
  localparam int ELEM_W  = 8;
  localparam int CNT_W   = 5;
  localparam int DEG_W   = 4;
  localparam int POLY_W  = 9;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_PERM  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_DEGREE = 2'd0,
    REG_POLY   = 2'd1,
    REG_ROWS   = 2'd2,
    REG_COLS   = 2'd3
  } reg_e;

  // Shift-and-add multiply, MSB first, reduced each step by x^e + poly.
  function automatic logic [ELEM_W-1:0] gf_mul(logic [ELEM_W-1:0] a,
                                               logic [ELEM_W-1:0] b,
                                               logic [DEG_W-1:0]  e,
                                               logic [POLY_W-1:0] poly);
    logic [ELEM_W-1:0] mask;
    logic [ELEM_W-1:0] am;
    logic [ELEM_W-1:0] bm;
    logic [POLY_W-1:0] red;
    logic [POLY_W-1:0] acc;
    mask = ELEM_W'((POLY_W'(1) << e) - POLY_W'(1));
    red  = (poly & {1'b0, mask}) | (POLY_W'(1) << e);
    am   = a & mask;
    bm   = b & mask;
    acc  = '0;
    for (int k = ELEM_W; k > 0; k--) begin
      if (k <= int'(e)) begin
        acc = {acc[POLY_W-2:0], 1'b0};
        if (acc[e]) acc = acc ^ red;
        if (bm[k-1]) acc = acc ^ {1'b0, am};
      end
    end
    return acc[ELEM_W-1:0] & mask;
  endfunction

endpackage

>>> rtl/gfple_if.sv
// ----------------------------------------------------------------------------
// gfple_req_if / gfple_rsp_if
// Valid/ready channels for commands and responses of the PLE block.
// ----------------------------------------------------------------------------
interface gfple_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [3:0] row_index;
  logic [3:0] column_index;
  logic [7:0] element_value;

  modport source (output valid, opcode, row_index, column_index, element_value,
                  input ready);
  modport sink (input valid, opcode, row_index, column_index, element_value,
                output ready);
endinterface

interface gfple_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] element_read;
  logic [3:0] pivot_row;
  logic [3:0] pivot_column;
  logic [4:0] rank;

  modport source (output valid, element_read, pivot_row, pivot_column, rank,
                  input ready);
  modport sink (input valid, element_read, pivot_row, pivot_column, rank,
                output ready);
endinterface

>>> rtl/gf2e_matrix_ple_decomposition.sv
// Timing: a write or permutation read answers in the cycle after acceptance; an
//   element read passes the RAM read register, then ST_RD_WAIT; a run searches,
//   swaps, inverts by linear search, scales and eliminates elements on the one RAM.
// Throughput: one transaction at a time; next accepted once the result drains.
// Reset: asynchronous, active low; matrix reads as zero through per-entry
//   valid bits, permutations and rank clear, registers take 8, 285, 16, 16.
// ----------------------------------------------------------------------------
// gf2e_matrix_ple_decomposition
// Matrix store over GF(2^e) with element access and in-place PLE decomposition.
// ----------------------------------------------------------------------------
module gf2e_matrix_ple_decomposition (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  gfple_req_if.sink                        req_i,
  gfple_rsp_if.source                      rsp_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gfple_pkg::PADDR_W-1:0]    paddr,
  input  logic [gfple_pkg::PDATA_W-1:0]    pwdata,
  output logic [gfple_pkg::PDATA_W-1:0]    prdata,
  output logic                             pready
);

  localparam int ROW_W  = gfple_pkg::ROW_W;
  localparam int COL_W  = gfple_pkg::COL_W;
  localparam int ADDR_W = gfple_pkg::ADDR_W;
  localparam int ELEM_W = gfple_pkg::ELEM_W;
  localparam int CNT_W  = gfple_pkg::CNT_W;
  localparam int DEG_W  = gfple_pkg::DEG_W;
  localparam int POLY_W = gfple_pkg::POLY_W;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_WAIT, ST_LOOP, ST_SRCH_RD, ST_SRCH_CHK,
    ST_SW_RA, ST_SW_RB, ST_SW_W1, ST_SW_W2, ST_INV,
    ST_SC_RD, ST_SC_WR, ST_EL_LOOP, ST_EL_T, ST_EL_C, ST_EL_RB, ST_EL_WR,
    ST_CS_START, ST_DONE
  } state_e;

  // configuration registers
  logic [DEG_W-1:0]  degree_q;
  logic [POLY_W-1:0] poly_q;
  logic [CNT_W-1:0]  rows_q;
  logic [CNT_W-1:0]  cols_q;

  logic cfg_we;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DEG_W'(8);
      poly_q   <= POLY_W'(285);
      rows_q   <= CNT_W'(16);
      cols_q   <= CNT_W'(16);
    end else if (cfg_we) begin
      unique case (gfple_pkg::reg_e'(paddr[3:2]))
        gfple_pkg::REG_DEGREE: degree_q <= pwdata[DEG_W-1:0];
        gfple_pkg::REG_POLY:   poly_q   <= pwdata[POLY_W-1:0];
        gfple_pkg::REG_ROWS:   rows_q   <= pwdata[CNT_W-1:0];
        gfple_pkg::REG_COLS:   cols_q   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (gfple_pkg::reg_e'(paddr[3:2]))
      gfple_pkg::REG_DEGREE: prdata = gfple_pkg::PDATA_W'(degree_q);
      gfple_pkg::REG_POLY:   prdata = gfple_pkg::PDATA_W'(poly_q);
      gfple_pkg::REG_ROWS:   prdata = gfple_pkg::PDATA_W'(rows_q);
      gfple_pkg::REG_COLS:   prdata = gfple_pkg::PDATA_W'(cols_q);
      default:               prdata = '0;
    endcase
  end

  // effective field and matrix size
  logic [DEG_W-1:0]  deg_e;
  logic [ELEM_W-1:0] mask;
  logic [CNT_W-1:0]  rcnt;
  logic [CNT_W-1:0]  ccnt;

  assign deg_e = (degree_q == '0) ? DEG_W'(1) :
                 (degree_q > DEG_W'(gfple_pkg::MAX_DEGREE)) ?
                 DEG_W'(gfple_pkg::MAX_DEGREE) : degree_q;
  assign mask  = ELEM_W'((POLY_W'(1) << deg_e) - POLY_W'(1));
  assign rcnt  = (rows_q > CNT_W'(gfple_pkg::MAX_ROWS)) ?
                 CNT_W'(gfple_pkg::MAX_ROWS) : rows_q;
  assign ccnt  = (cols_q > CNT_W'(gfple_pkg::MAX_COLUMNS)) ?
                 CNT_W'(gfple_pkg::MAX_COLUMNS) : cols_q;

  // sequencer registers
  state_e             state_q;
  logic [CNT_W-1:0]   rp_q, cp_q, i_q, j_q, c_q, l_q;
  logic [ELEM_W-1:0]  piv_q, s_q, t_q, x_q, a_q;
  logic               col_mode_q;
  logic [CNT_W-1:0]   rank_q;
  logic [ROW_W-1:0]   perm_r_q [gfple_pkg::MAX_ROWS];
  logic [COL_W-1:0]   perm_c_q [gfple_pkg::MAX_ROWS];

  logic               out_vld_q;
  logic [ELEM_W-1:0]  out_elem_q;
  logic [ROW_W-1:0]   out_pr_q;
  logic [COL_W-1:0]   out_pc_q;
  logic [CNT_W-1:0]   out_rank_q;

  // matrix RAM with per-entry valid bits
  logic [ELEM_W-1:0]  mem [gfple_pkg::DEPTH];
  logic [gfple_pkg::DEPTH-1:0] vld_q;
  logic [ELEM_W-1:0]  rdat_q;
  logic               rvld_q;
  logic [ELEM_W-1:0]  rd;
  logic               we;
  logic [ADDR_W-1:0]  wa, ra;
  logic [ELEM_W-1:0]  wd;

  assign rd = rvld_q ? rdat_q : '0;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rdat_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we) vld_q[wa] <= 1'b1;
      rvld_q <= vld_q[ra];
    end
  end

  logic acc_in;
  assign req_i.ready = (state_q == ST_IDLE) && (!out_vld_q || rsp_o.ready);
  assign acc_in      = req_i.valid && req_i.ready;

  // swap endpoints: row swap (pivot row vs found row) or column swap
  logic [ADDR_W-1:0] sw_a, sw_b;
  assign sw_a = col_mode_q ? {l_q[ROW_W-1:0], c_q[COL_W-1:0]}
                           : {rp_q[ROW_W-1:0], c_q[COL_W-1:0]};
  assign sw_b = col_mode_q ? {l_q[ROW_W-1:0], perm_c_q[c_q[ROW_W-1:0]]}
                           : {i_q[ROW_W-1:0], c_q[COL_W-1:0]};

  logic [ELEM_W-1:0] mul_a, mul_b, prod;
  assign prod = gfple_pkg::gf_mul(mul_a, mul_b, deg_e, poly_q);

  always_comb begin
    we    = 1'b0;
    wa    = '0;
    wd    = '0;
    ra    = '0;
    mul_a = piv_q;
    mul_b = x_q;
    unique case (state_q)
      ST_IDLE: begin
        ra = {req_i.row_index, req_i.column_index};
        wa = {req_i.row_index, req_i.column_index};
        wd = req_i.element_value & mask;
        we = acc_in && (gfple_pkg::op_e'(req_i.opcode) == gfple_pkg::OP_WRITE);
      end
      ST_SRCH_RD: ra = {i_q[ROW_W-1:0], j_q[COL_W-1:0]};
      ST_SW_RA:   ra = sw_a;
      ST_SW_RB:   ra = sw_b;
      ST_SW_W1: begin
        we = 1'b1;
        wa = sw_a;
        wd = rd;
      end
      ST_SW_W2: begin
        we = 1'b1;
        wa = sw_b;
        wd = a_q;
      end
      ST_SC_RD: ra = {rp_q[ROW_W-1:0], c_q[COL_W-1:0]};
      ST_SC_WR: begin
        mul_a = rd;
        mul_b = s_q;
        we    = 1'b1;
        wa    = {rp_q[ROW_W-1:0], c_q[COL_W-1:0]};
        wd    = prod;
      end
      ST_EL_LOOP: ra = {l_q[ROW_W-1:0], j_q[COL_W-1:0]};
      ST_EL_C:    ra = {l_q[ROW_W-1:0], c_q[COL_W-1:0]};
      ST_EL_RB:   ra = {rp_q[ROW_W-1:0], c_q[COL_W-1:0]};
      ST_EL_WR: begin
        mul_a = t_q;
        mul_b = rd;
        we    = 1'b1;
        wa    = {l_q[ROW_W-1:0], c_q[COL_W-1:0]};
        wd    = a_q ^ prod;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rp_q       <= '0;
      cp_q       <= '0;
      i_q        <= '0;
      j_q        <= '0;
      c_q        <= '0;
      l_q        <= '0;
      piv_q      <= '0;
      s_q        <= '0;
      t_q        <= '0;
      x_q        <= '0;
      a_q        <= '0;
      col_mode_q <= 1'b0;
      rank_q     <= '0;
      out_vld_q  <= 1'b0;
      out_elem_q <= '0;
      out_pr_q   <= '0;
      out_pc_q   <= '0;
      out_rank_q <= '0;
      for (int k = 0; k < gfple_pkg::MAX_ROWS; k++) begin
        perm_r_q[k] <= '0;
        perm_c_q[k] <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (acc_in) begin
            out_elem_q <= '0;
            out_pr_q   <= '0;
            out_pc_q   <= '0;
            out_rank_q <= rank_q;
            unique case (gfple_pkg::op_e'(req_i.opcode))
              gfple_pkg::OP_WRITE: out_vld_q <= 1'b1;
              gfple_pkg::OP_READ: begin
                out_vld_q <= 1'b0;
                state_q   <= ST_RD_WAIT;
              end
              gfple_pkg::OP_PERM: begin
                out_pr_q  <= perm_r_q[req_i.row_index];
                out_pc_q  <= perm_c_q[req_i.row_index];
                out_vld_q <= 1'b1;
              end
              gfple_pkg::OP_RUN: begin
                out_vld_q <= 1'b0;
                rp_q      <= '0;
                cp_q      <= '0;
                state_q   <= ST_LOOP;
              end
              default: ;
            endcase
          end else if (rsp_o.ready) begin
            out_vld_q <= 1'b0;
          end
        end
        ST_RD_WAIT: begin
          out_elem_q <= rd & mask;
          out_vld_q  <= 1'b1;
          state_q    <= ST_IDLE;
        end
        ST_LOOP: begin
          if (rp_q < rcnt && cp_q < ccnt) begin
            j_q     <= cp_q;
            i_q     <= rp_q;
            state_q <= ST_SRCH_RD;
          end else begin
            state_q <= ST_CS_START;
          end
        end
        ST_SRCH_RD: state_q <= ST_SRCH_CHK;
        ST_SRCH_CHK: begin
          priority if ((rd & mask) != '0) begin
            perm_r_q[rp_q[ROW_W-1:0]] <= i_q[ROW_W-1:0];
            perm_c_q[rp_q[ROW_W-1:0]] <= j_q[COL_W-1:0];
            piv_q      <= rd & mask;
            c_q        <= '0;
            col_mode_q <= 1'b0;
            state_q    <= ST_SW_RA;
          end else if (i_q + CNT_W'(1) < rcnt) begin
            i_q     <= i_q + CNT_W'(1);
            state_q <= ST_SRCH_RD;
          end else if (j_q + CNT_W'(1) < ccnt) begin
            j_q     <= j_q + CNT_W'(1);
            i_q     <= rp_q;
            state_q <= ST_SRCH_RD;
          end else begin
            state_q <= ST_CS_START;
          end
        end
        ST_SW_RA: state_q <= ST_SW_RB;
        ST_SW_RB: begin
          a_q     <= rd;
          state_q <= ST_SW_W1;
        end
        ST_SW_W1: state_q <= ST_SW_W2;
        ST_SW_W2: begin
          if (!col_mode_q) begin
            if (c_q == CNT_W'(gfple_pkg::MAX_COLUMNS - 1)) begin
              x_q     <= ELEM_W'(1);
              state_q <= ST_INV;
            end else begin
              c_q     <= c_q + CNT_W'(1);
              state_q <= ST_SW_RA;
            end
          end else begin
            priority if (l_q + CNT_W'(1) < rcnt) begin
              l_q     <= l_q + CNT_W'(1);
              state_q <= ST_SW_RA;
            end else if (c_q + CNT_W'(1) < rp_q) begin
              c_q     <= c_q + CNT_W'(1);
              l_q     <= c_q + CNT_W'(1);
              state_q <= ST_SW_RA;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_INV: begin
          // linear search for the inverse; zero when none exists
          priority if (prod == ELEM_W'(1)) begin
            s_q     <= x_q;
            c_q     <= j_q + CNT_W'(1);
            state_q <= ST_SC_RD;
          end else if (x_q == mask) begin
            s_q     <= '0;
            c_q     <= j_q + CNT_W'(1);
            state_q <= ST_SC_RD;
          end else begin
            x_q <= x_q + ELEM_W'(1);
          end
        end
        ST_SC_RD: begin
          if (c_q < ccnt) begin
            state_q <= ST_SC_WR;
          end else begin
            l_q     <= rp_q + CNT_W'(1);
            state_q <= ST_EL_LOOP;
          end
        end
        ST_SC_WR: begin
          c_q     <= c_q + CNT_W'(1);
          state_q <= ST_SC_RD;
        end
        ST_EL_LOOP: begin
          if (l_q < rcnt) begin
            state_q <= ST_EL_T;
          end else begin
            rp_q    <= rp_q + CNT_W'(1);
            cp_q    <= j_q + CNT_W'(1);
            state_q <= ST_LOOP;
          end
        end
        ST_EL_T: begin
          if ((rd & mask) == '0) begin
            l_q     <= l_q + CNT_W'(1);
            state_q <= ST_EL_LOOP;
          end else begin
            t_q     <= rd & mask;
            c_q     <= j_q + CNT_W'(1);
            state_q <= ST_EL_C;
          end
        end
        ST_EL_C: begin
          if (c_q < ccnt) begin
            state_q <= ST_EL_RB;
          end else begin
            l_q     <= l_q + CNT_W'(1);
            state_q <= ST_EL_LOOP;
          end
        end
        ST_EL_RB: begin
          a_q     <= rd & mask;
          state_q <= ST_EL_WR;
        end
        ST_EL_WR: begin
          c_q     <= c_q + CNT_W'(1);
          state_q <= ST_EL_C;
        end
        ST_CS_START: begin
          if (rp_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            c_q        <= '0;
            l_q        <= '0;
            col_mode_q <= 1'b1;
            state_q    <= ST_SW_RA;
          end
        end
        ST_DONE: begin
          rank_q     <= rp_q;
          out_rank_q <= rp_q;
          out_vld_q  <= 1'b1;
          state_q    <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.element_read = out_elem_q;
  assign rsp_o.pivot_row    = out_pr_q;
  assign rsp_o.pivot_column = out_pc_q;
  assign rsp_o.rank         = out_rank_q;

`ifndef SYNTHESIS
  a_rank_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rank_q <= CNT_W'(gfple_pkg::MAX_ROWS))
    else $error("rank exceeds row limit");

  a_run_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && req_i.opcode == gfple_pkg::OP_RUN) |=> state_q == ST_LOOP)
    else $error("run command did not start sequencer");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SRCH_CHK |-> (i_q < rcnt && j_q < ccnt))
    else $error("pivot search out of bounds");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in |-> state_q == ST_IDLE)
    else $error("transaction accepted while busy");
`endif

endmodule
